@@ design/assert_macros.svh @@
// Assertion macros shared by mbc1_bank_regs and mbc1_bank_controller_unit.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/mbc1_pkg.sv @@
// Types and constants for the mbc1 bank controller.
// No dependencies.
package mbc1_pkg;

    localparam int unsigned ROM_OFS_W  = 14;  // 16 KiB ROM bank
    localparam int unsigned RAM_OFS_W  = 13;  // 8 KiB RAM bank
    localparam int unsigned ROM_BANK_W = 7;
    localparam int unsigned RAM_BANK_W = 2;
    localparam int unsigned PHYS_W     = 21;

    typedef enum logic [1:0] {
        OP_ROM_READ  = 2'd0,
        OP_CTL_WRITE = 2'd1,
        OP_RAM_READ  = 2'd2,
        OP_RAM_WRITE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2,
        TGT_RSVD = 2'd3
    } target_t;

    // Control register select, address bits 14..13 (bit 15 must be clear)
    typedef enum logic [1:0] {
        CTL_RAM_ENABLE = 2'd0,
        CTL_BANK_LOW   = 2'd1,
        CTL_BANK_HIGH  = 2'd2,
        CTL_MODE       = 2'd3
    } ctl_sel_t;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_enabled;
        logic                  banking_mode;
    } bank_state_t;

    typedef struct packed {
        target_t           target;
        logic [PHYS_W-1:0] phys_address;
        logic              write_strobe;
        logic [7:0]        write_data;
        logic              read_zero;
        logic              status;
    } result_t;

endpackage

@@ design/mbc1_addr_map.sv @@
// Combinational decode of one bus access: address mapping and next bank state.
// Depends on mbc1_pkg.
module mbc1_addr_map (
    input  logic [1:0]            op,
    input  logic [15:0]           address,
    input  logic [7:0]            data,
    input  mbc1_pkg::bank_state_t state_cur,
    output mbc1_pkg::bank_state_t state_next,
    output mbc1_pkg::result_t     result
);
    import mbc1_pkg::*;

    logic [4:0] bank_low;

    assign bank_low = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];

    always_comb begin
        state_next = state_cur;
        result     = '0;
        result.target = TGT_NONE;
        unique case (op_t'(op))
            OP_ROM_READ: begin
                if (address[15:ROM_OFS_W] == 2'b00) begin
                    result.target       = TGT_ROM;
                    result.phys_address = {{(PHYS_W-16){1'b0}}, address};
                end else if (address[15:ROM_OFS_W] == 2'b01) begin
                    result.target       = TGT_ROM;
                    result.phys_address = {state_cur.rom_bank, address[ROM_OFS_W-1:0]};
                end
            end
            OP_CTL_WRITE: begin
                if (address[15]) begin
                    result.status = 1'b1;
                end else begin
                    unique case (ctl_sel_t'(address[14:13]))
                        CTL_RAM_ENABLE: state_next.ram_enabled = (data[3:0] == RAM_ENABLE_KEY);
                        CTL_BANK_LOW:   state_next.rom_bank[4:0] = bank_low;
                        CTL_BANK_HIGH: begin
                            if (state_cur.banking_mode)
                                state_next.ram_bank = data[1:0];
                            else
                                state_next.rom_bank[6:5] = data[1:0];
                        end
                        CTL_MODE: begin
                            if (data != 8'd0) begin
                                state_next.banking_mode  = 1'b1;
                                state_next.rom_bank[6:5] = 2'b00;
                            end else begin
                                state_next.banking_mode = 1'b0;
                                state_next.ram_bank     = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_RAM_READ, OP_RAM_WRITE: begin
                if (state_cur.ram_enabled) begin
                    result.target       = TGT_RAM;
                    result.phys_address = {{(PHYS_W-RAM_BANK_W-RAM_OFS_W){1'b0}},
                                           state_cur.ram_bank, address[RAM_OFS_W-1:0]};
                    if (op_t'(op) == OP_RAM_WRITE) begin
                        result.write_strobe = 1'b1;
                        result.write_data   = data;
                    end
                end else if (op_t'(op) == OP_RAM_READ) begin
                    result.read_zero = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ design/mbc1_bank_regs.sv @@
// Bank state registers of the mbc1 controller, loaded once per processed item.
// Depends on mbc1_pkg and assert_macros.svh.
module mbc1_bank_regs (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  mbc1_pkg::bank_state_t state_next,
    output mbc1_pkg::bank_state_t state_cur
);
    import mbc1_pkg::*;

    bank_state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.rom_bank     <= ROM_BANK_W'(1);
            state_reg.ram_bank     <= '0;
            state_reg.ram_enabled  <= 1'b0;
            state_reg.banking_mode <= 1'b0;
        end else if (load) begin
            state_reg <= state_next;
        end
    end

    assign state_cur = state_reg;

`include "assert_macros.svh"

    // low five bank bits can never be zero
    `ASSERT_IMPL(a_bank_low_nonzero, aclk, aresetn, 1'b1, state_reg.rom_bank[4:0] != 5'd0)
    // RAM bank only moves away from zero in RAM banking mode
    `ASSERT_IMPL(a_ram_bank_mode0, aclk, aresetn, !state_reg.banking_mode,
                 state_reg.ram_bank == '0)
    // state holds when no item is processed
    `ASSERT_NEXT(a_state_hold, aclk, aresetn, !load, $stable(state_reg))

endmodule

@@ design/mbc1_bank_controller_unit.sv @@
// Top level of the mbc1 bank controller: input register, decode, result register.
// Depends on mbc1_pkg, mbc1_addr_map, mbc1_bank_regs and assert_macros.svh.
//
// Usage:
//   Slave channel s_*: one bus access per item. s_tuser holds op (0 ROM read,
//   1 control write, 2 RAM read, 3 RAM write); s_tdata holds address and data.
//   Master channel m_*: exactly one result item per input item, in order.
//   m_tuser holds target (0 none, 1 ROM, 2 RAM); m_tdata holds the physical
//   address, write strobe, write data, read-zero flag and status.
//   Path: an accepted item passes through the input register, then the result
//   register, before m_tvalid rises. Throughput: one item per cycle while
//   m_tready is high; the bank state is read and updated by the same decode
//   that fills the result register, so an item sees every control write
//   accepted before it.
//   Reset (aresetn low, synchronous): both stages empty, ROM bank 1, RAM bank 0,
//   RAM disabled, ROM banking mode.
//   Stall: while m_tready is low the result holds; the input register still
//   takes one more item, after which s_tready drops until the result drains.
module mbc1_bank_controller_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // [15:0] address, [23:16] data
    input  logic [1:0]  s_tuser,  // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [20:0] phys_address, [21] write_strobe,
                                  // [29:22] write_data, [30] read_zero, [31] status
    output logic [1:0]  m_tuser   // [1:0] target
);
    import mbc1_pkg::*;

    // input stage
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [15:0] address_reg;
    logic [7:0]  data_reg;

    // result stage
    logic        out_valid_reg;
    result_t     result_reg;

    logic        advance;
    logic        s_fire;
    bank_state_t state_cur;
    bank_state_t state_next;
    result_t     result_next;

    // input item moves to the result register when that register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg      <= s_tuser;
            address_reg <= s_tdata[15:0];
            data_reg    <= s_tdata[23:16];
        end
    end

    mbc1_addr_map u_map (
        .op         (op_reg),
        .address    (address_reg),
        .data       (data_reg),
        .state_cur  (state_cur),
        .state_next (state_next),
        .result     (result_next)
    );

    mbc1_bank_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .state_next (state_next),
        .state_cur  (state_cur)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.target;
    assign m_tdata  = {result_reg.status, result_reg.read_zero, result_reg.write_data,
                       result_reg.write_strobe, result_reg.phys_address};

`include "assert_macros.svh"

    // a RAM write strobe only goes out with a RAM target
    `ASSERT_IMPL(a_strobe_ram, aclk, aresetn, m_tvalid && result_reg.write_strobe,
                 result_reg.target == TGT_RAM)
    // a zero read never carries a memory access
    `ASSERT_IMPL(a_zero_no_access, aclk, aresetn, m_tvalid && result_reg.read_zero,
                 result_reg.target == TGT_NONE && result_reg.phys_address == '0)
    // a stalled result is never overwritten by the input stage
    `ASSERT_IMPL(a_no_overwrite, aclk, aresetn, out_valid_reg && !m_tready, !advance)

endmodule
